[rtl/mpps_pkg.sv]
package mpps_pkg;

  // Width of the value ports. The arithmetic width inside the block is VALUE_WIDTH.
  localparam int DATA_W = 32;
  localparam int VALUE_WIDTH_DEF = 32;

  // Zeros are counted only as far as the selection needs: none, one, two or more.
  localparam int ZCNT_W = 2;
  localparam logic [ZCNT_W-1:0] ZCNT_SAT = ZCNT_W'(2);

  // Validity marks and zero summary of one finished set.
  typedef struct packed {
    logic pos_top_ok;
    logic pos_second_ok;
    logic neg_top_ok;
    logic neg_second_ok;
    logic zero_any;
    logic zero_multi;
  } snap_flags_t;

endpackage

[rtl/max_product_pair_select.sv]
// Channel | Ports                                   | Direction
// input   | in_valid, in_ready, in_value, in_last   | into the block
// result  | out_valid, out_ready, out_first_value,  | out of the block
//         | out_second_value                        |
//
// One item is accepted every cycle while in_ready is high. After the last item of a set
// is accepted it passes the input register, the running state, the products and the
// result register before out_valid rises.
// Reset is synchronous and active low and clears every valid bit and the running state.
// A stalled result holds the whole pipeline; a two-entry input (register plus skid slot)
// keeps in_ready a registered signal, so it never depends on out_ready in the same cycle.
module max_product_pair_select #(
  parameter int VALUE_WIDTH = mpps_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [mpps_pkg::DATA_W-1:0]   in_value,
  input  logic                                 in_last,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [mpps_pkg::DATA_W-1:0]   out_first_value,
  output logic signed [mpps_pkg::DATA_W-1:0]   out_second_value
);

  localparam int PROD_W = 2 * VALUE_WIDTH;

  logic                          adv, accept;
  logic signed [VALUE_WIDTH-1:0] in_val_w;

  logic                          skid_valid_r;
  logic signed [VALUE_WIDTH-1:0] skid_value_r;
  logic                          skid_last_r;

  logic                          s1_valid_r;
  logic signed [VALUE_WIDTH-1:0] s1_value_r;
  logic                          s1_last_r;

  logic                          snap_valid_r;
  logic signed [VALUE_WIDTH-1:0] snap_pos_top_r, snap_pos_second_r;
  logic signed [VALUE_WIDTH-1:0] snap_neg_top_r, snap_neg_second_r;
  mpps_pkg::snap_flags_t         snap_flags_r;

  logic                          s3_valid_r;
  logic signed [VALUE_WIDTH-1:0] s3_pos_top_r, s3_pos_second_r;
  logic signed [VALUE_WIDTH-1:0] s3_neg_top_r, s3_neg_second_r;
  mpps_pkg::snap_flags_t         s3_flags_r;
  logic signed [PROD_W-1:0]      s3_prod_pos_r, s3_prod_neg_r;

  logic signed [VALUE_WIDTH-1:0] first_nxt, second_nxt;
  logic                          out_valid_r;
  logic signed [VALUE_WIDTH-1:0] out_first_r, out_second_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = !skid_valid_r;
  assign accept   = in_valid && in_ready;
  assign in_val_w = in_value[VALUE_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_valid_r <= 1'b0;
      s1_valid_r   <= 1'b0;
    end else if (adv) begin
      s1_valid_r   <= skid_valid_r || accept;
      skid_valid_r <= skid_valid_r && accept;
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (skid_valid_r) begin
        s1_value_r <= skid_value_r;
        s1_last_r  <= skid_last_r;
      end else begin
        s1_value_r <= in_val_w;
        s1_last_r  <= in_last;
      end
    end
    if (accept && (skid_valid_r || !adv)) begin
      skid_value_r <= in_val_w;
      skid_last_r  <= in_last;
    end
  end

  mpps_tracker #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_tracker (
    .clk              (clk),
    .rst_n            (rst_n),
    .adv              (adv),
    .item_valid       (s1_valid_r),
    .item_value       (s1_value_r),
    .item_last        (s1_last_r),
    .snap_valid_r     (snap_valid_r),
    .snap_pos_top_r   (snap_pos_top_r),
    .snap_pos_second_r(snap_pos_second_r),
    .snap_neg_top_r   (snap_neg_top_r),
    .snap_neg_second_r(snap_neg_second_r),
    .snap_flags_r     (snap_flags_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= snap_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_pos_top_r    <= snap_pos_top_r;
      s3_pos_second_r <= snap_pos_second_r;
      s3_neg_top_r    <= snap_neg_top_r;
      s3_neg_second_r <= snap_neg_second_r;
      s3_flags_r      <= snap_flags_r;
      s3_prod_pos_r   <= PROD_W'(snap_pos_top_r) * PROD_W'(snap_pos_second_r);
      s3_prod_neg_r   <= PROD_W'(snap_neg_top_r) * PROD_W'(snap_neg_second_r);
    end
  end

  // Fallback order: all zeros, a single nonzero value, both sign pairs (negative pair
  // wins ties), one sign pair, then one value of each sign (negative and zero if any zero).
  always_comb begin
    first_nxt  = '0;
    second_nxt = '0;
    if (!s3_flags_r.pos_top_ok && !s3_flags_r.neg_top_ok) begin
      first_nxt  = '0;
      second_nxt = '0;
    end else if (!s3_flags_r.pos_second_ok && !s3_flags_r.neg_second_ok &&
                 (s3_flags_r.pos_top_ok != s3_flags_r.neg_top_ok)) begin
      if (s3_flags_r.neg_top_ok) begin
        first_nxt = s3_neg_top_r;
      end else if (!s3_flags_r.zero_multi) begin
        second_nxt = s3_pos_top_r;
      end
    end else if (s3_flags_r.pos_second_ok && s3_flags_r.neg_second_ok) begin
      if (s3_prod_neg_r >= s3_prod_pos_r) begin
        first_nxt  = s3_neg_top_r;
        second_nxt = s3_neg_second_r;
      end else begin
        first_nxt  = s3_pos_second_r;
        second_nxt = s3_pos_top_r;
      end
    end else if (s3_flags_r.pos_second_ok) begin
      first_nxt  = s3_pos_second_r;
      second_nxt = s3_pos_top_r;
    end else if (s3_flags_r.neg_second_ok) begin
      first_nxt  = s3_neg_top_r;
      second_nxt = s3_neg_second_r;
    end else if (s3_flags_r.zero_any) begin
      first_nxt = s3_neg_top_r;
    end else begin
      first_nxt  = s3_neg_top_r;
      second_nxt = s3_pos_top_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_first_r  <= first_nxt;
      out_second_r <= second_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_first_value  = mpps_pkg::DATA_W'(out_first_r);
  assign out_second_value = mpps_pkg::DATA_W'(out_second_r);

endmodule

[rtl/mpps_tracker.sv]
module mpps_tracker #(
  parameter int VALUE_WIDTH = mpps_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          item_valid,
  input  logic signed [VALUE_WIDTH-1:0] item_value,
  input  logic                          item_last,
  output logic                          snap_valid_r,
  output logic signed [VALUE_WIDTH-1:0] snap_pos_top_r,
  output logic signed [VALUE_WIDTH-1:0] snap_pos_second_r,
  output logic signed [VALUE_WIDTH-1:0] snap_neg_top_r,
  output logic signed [VALUE_WIDTH-1:0] snap_neg_second_r,
  output mpps_pkg::snap_flags_t         snap_flags_r
);

  logic signed [VALUE_WIDTH-1:0] pos_top_r, pos_second_r, neg_top_r, neg_second_r;
  logic signed [VALUE_WIDTH-1:0] pos_top_nxt, pos_second_nxt, neg_top_nxt, neg_second_nxt;
  logic                          p1_r, p2_r, n1_r, n2_r;
  logic                          p1_nxt, p2_nxt, n1_nxt, n2_nxt;
  logic [mpps_pkg::ZCNT_W-1:0]   zero_cnt_r, zero_cnt_nxt;
  logic                          is_zero, is_pos;
  logic                          take;

  assign take = adv && item_valid;

  always_comb begin
    pos_top_nxt    = pos_top_r;
    pos_second_nxt = pos_second_r;
    neg_top_nxt    = neg_top_r;
    neg_second_nxt = neg_second_r;
    p1_nxt         = p1_r;
    p2_nxt         = p2_r;
    n1_nxt         = n1_r;
    n2_nxt         = n2_r;
    zero_cnt_nxt   = zero_cnt_r;
    is_zero        = (item_value == '0);
    is_pos         = !is_zero && !item_value[VALUE_WIDTH-1];
    if (is_zero) begin
      if (zero_cnt_r != mpps_pkg::ZCNT_SAT) begin
        zero_cnt_nxt = zero_cnt_r + mpps_pkg::ZCNT_W'(1);
      end
    end else if (is_pos) begin
      if (!p1_r || item_value > pos_top_r) begin
        pos_second_nxt = pos_top_r;
        p2_nxt         = p1_r;
        pos_top_nxt    = item_value;
        p1_nxt         = 1'b1;
      end else if (!p2_r || item_value > pos_second_r) begin
        pos_second_nxt = item_value;
        p2_nxt         = 1'b1;
      end
    end else begin
      if (!n1_r || item_value < neg_top_r) begin
        neg_second_nxt = neg_top_r;
        n2_nxt         = n1_r;
        neg_top_nxt    = item_value;
        n1_nxt         = 1'b1;
      end else if (!n2_r || item_value < neg_second_r) begin
        neg_second_nxt = item_value;
        n2_nxt         = 1'b1;
      end
    end
  end

  // Running state; the last item of a set leaves it cleared for the next set.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r       <= 1'b0;
      p2_r       <= 1'b0;
      n1_r       <= 1'b0;
      n2_r       <= 1'b0;
      zero_cnt_r <= '0;
    end else if (take) begin
      if (item_last) begin
        p1_r       <= 1'b0;
        p2_r       <= 1'b0;
        n1_r       <= 1'b0;
        n2_r       <= 1'b0;
        zero_cnt_r <= '0;
      end else begin
        p1_r       <= p1_nxt;
        p2_r       <= p2_nxt;
        n1_r       <= n1_nxt;
        n2_r       <= n2_nxt;
        zero_cnt_r <= zero_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pos_top_r    <= pos_top_nxt;
      pos_second_r <= pos_second_nxt;
      neg_top_r    <= neg_top_nxt;
      neg_second_r <= neg_second_nxt;
    end
  end

  // Snapshot of a finished set, valid only behind a last item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_valid_r <= 1'b0;
    end else if (adv) begin
      snap_valid_r <= item_valid && item_last;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      snap_pos_top_r             <= pos_top_nxt;
      snap_pos_second_r          <= pos_second_nxt;
      snap_neg_top_r             <= neg_top_nxt;
      snap_neg_second_r          <= neg_second_nxt;
      snap_flags_r.pos_top_ok    <= p1_nxt;
      snap_flags_r.pos_second_ok <= p2_nxt;
      snap_flags_r.neg_top_ok    <= n1_nxt;
      snap_flags_r.neg_second_ok <= n2_nxt;
      snap_flags_r.zero_any      <= (zero_cnt_nxt != '0);
      snap_flags_r.zero_multi    <= (zero_cnt_nxt == mpps_pkg::ZCNT_SAT);
    end
  end

endmodule
